>>> rtl/rsr_pkg.sv
`default_nettype none

package rsr_pkg;

   localparam int PosBits     = 24;
   localparam int PageBits    = 24;
   localparam int CmpBits     = ((PosBits > PageBits) ? PosBits : PageBits) + 2;
   localparam int MaxResults  = 4;
   localparam int PushBits    = $clog2(MaxResults + 1);
   localparam int FifoDepth   = 16;
   localparam int FifoAddrBits = $clog2(FifoDepth);
   localparam int CountBits   = FifoAddrBits + 1;
   localparam int StallLevel  = FifoDepth - 2 * MaxResults;
   localparam int LenBits     = 17;

   localparam logic [7:0]  RecordIntro = 8'h5A;
   localparam logic [7:0]  RecordClass = 8'hD3;
   localparam logic [15:0] MinLength   = 16'd8;
   localparam int          MinRemain   = 9;
   localparam logic [3:0]  SeqHiOffset = 4'd7;
   localparam logic [3:0]  SeqLoOffset = 4'd8;
   localparam logic [3:0]  OffsetLimit = 4'd9;
   localparam logic [15:0] SeqReset    = 16'd2;
   localparam logic [PageBits-1:0] PageSizeReset = PageBits'(1);

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        page_done;
      logic [15:0] next_sequence;
   } result_type;

   typedef struct packed {
      logic [PushBits-1:0]            count;
      result_type [MaxResults-1:0]    items;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/rsr_fifo.sv
`default_nettype none

module rsr_fifo (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rsr_pkg::push_type              push,
   input  wire logic                           pop,
   output rsr_pkg::result_type                 head,
   output logic [rsr_pkg::CountBits-1:0]       count
);

   rsr_pkg::result_type [rsr_pkg::FifoDepth-1:0] mem_ff, mem_in;
   logic [rsr_pkg::FifoAddrBits-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [rsr_pkg::CountBits-1:0]    cnt_ff, cnt_in;

   always_comb begin
      mem_in = mem_ff;
      for (int i = 0; i < rsr_pkg::MaxResults; i++) begin
         if (rsr_pkg::PushBits'(i) < push.count) begin
            mem_in[wp_ff + rsr_pkg::FifoAddrBits'(i)] = push.items[i];
         end
      end
      wp_in  = wp_ff + rsr_pkg::FifoAddrBits'(push.count);
      rp_in  = pop ? rp_ff + rsr_pkg::FifoAddrBits'(1) : rp_ff;
      cnt_in = cnt_ff + rsr_pkg::CountBits'(push.count)
               - (pop ? rsr_pkg::CountBits'(1) : rsr_pkg::CountBits'(0));
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head  = mem_ff[rp_ff];
   assign count = cnt_ff;

endmodule

`default_nettype wire

>>> rtl/rsr_core.sv
`default_nettype none

module rsr_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [7:0]                    in_byte,
   input  wire logic [rsr_pkg::PageBits-1:0]  page_size,
   output rsr_pkg::push_type                  push
);

   logic [rsr_pkg::PosBits-1:0]  pos_ff, pos_in;
   logic [2:0][7:0]              win_ff, win_in;
   logic [rsr_pkg::LenBits-1:0]  rbl_ff, rbl_in;
   logic [3:0]                   off_ff, off_in;
   logic [15:0]                  aseq_ff, aseq_in;
   logic [15:0]                  seq_ff, seq_in;

   logic [1:0]                   held;
   logic                         last;
   logic [rsr_pkg::PushBits-1:0] emit;
   logic [3:0][7:0]              bytes;
   logic [rsr_pkg::PosBits-1:0]  rec_pos;
   logic [15:0]                  len;
   logic [rsr_pkg::CmpBits-1:0]  lim;
   logic                         start;
   logic [7:0]                   b;
   logic [rsr_pkg::LenBits-1:0]  rbl;
   logic [3:0]                   off;

   always_comb begin
      held = (pos_ff < rsr_pkg::PosBits'(3)) ? pos_ff[1:0] : 2'd3;
      last = (rsr_pkg::CmpBits'(pos_ff) + rsr_pkg::CmpBits'(1))
             >= rsr_pkg::CmpBits'(page_size);
      if (last) begin
         emit = rsr_pkg::PushBits'(held) + rsr_pkg::PushBits'(1);
      end else begin
         emit = (held == 2'd3) ? rsr_pkg::PushBits'(1) : rsr_pkg::PushBits'(0);
      end

      bytes = '0;
      unique case (held)
         2'd0: begin
            bytes[0] = in_byte;
         end
         2'd1: begin
            bytes[0] = win_ff[2];
            bytes[1] = in_byte;
         end
         2'd2: begin
            bytes[0] = win_ff[1];
            bytes[1] = win_ff[2];
            bytes[2] = in_byte;
         end
         2'd3: begin
            bytes[0] = win_ff[0];
            bytes[1] = win_ff[1];
            bytes[2] = win_ff[2];
            bytes[3] = in_byte;
         end
      endcase

      // record header check on the oldest byte, full lookahead only
      rec_pos = pos_ff - rsr_pkg::PosBits'(3);
      len     = {win_ff[1], win_ff[2]};
      lim     = (page_size == '0) ? rsr_pkg::CmpBits'(1) : rsr_pkg::CmpBits'(page_size);
      start   = (rbl_ff == '0) && (held == 2'd3)
                && (win_ff[0] == rsr_pkg::RecordIntro) && (in_byte == rsr_pkg::RecordClass)
                && (len >= rsr_pkg::MinLength)
                && (rsr_pkg::CmpBits'(rec_pos) + rsr_pkg::CmpBits'(len)
                    + rsr_pkg::CmpBits'(1) <= lim)
                && (rsr_pkg::CmpBits'(rec_pos) + rsr_pkg::CmpBits'(rsr_pkg::MinRemain) <= lim);

      rbl     = start ? rsr_pkg::LenBits'(len) + rsr_pkg::LenBits'(1) : rbl_ff;
      off     = start ? 4'd0 : off_ff;
      aseq_in = start ? seq_ff : aseq_ff;
      seq_in  = start ? seq_ff + 16'd1 : seq_ff;

      push.count = in_valid ? emit : '0;
      for (int i = 0; i < rsr_pkg::MaxResults; i++) begin
         b = bytes[i];
         if ((rsr_pkg::PushBits'(i) < emit) && (rbl != '0)) begin
            if (off == rsr_pkg::SeqHiOffset) begin
               b = aseq_in[15:8];
            end else if (off == rsr_pkg::SeqLoOffset) begin
               b = aseq_in[7:0];
            end
            if (off < rsr_pkg::OffsetLimit) begin
               off = off + 4'd1;
            end
            rbl = rbl - rsr_pkg::LenBits'(1);
         end
         push.items[i].out_byte      = b;
         push.items[i].page_done     = last
                                       && (rsr_pkg::PushBits'(i) + rsr_pkg::PushBits'(1) == emit);
         push.items[i].next_sequence = seq_in;
      end

      if (last) begin
         win_in = '0;
         pos_in = '0;
         rbl_in = '0;
         off_in = '0;
      end else begin
         win_in = {in_byte, win_ff[2], win_ff[1]};
         pos_in = pos_ff + rsr_pkg::PosBits'(1);
         rbl_in = rbl;
         off_in = off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         win_ff  <= '0;
         rbl_ff  <= '0;
         off_ff  <= '0;
         aseq_ff <= '0;
         seq_ff  <= rsr_pkg::SeqReset;
      end else if (in_valid) begin
         pos_ff  <= pos_in;
         win_ff  <= win_in;
         rbl_ff  <= rbl_in;
         off_ff  <= off_in;
         aseq_ff <= aseq_in;
         seq_ff  <= seq_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/record_sequence_renumberer_top.sv
// Result path: a byte's result is on rsp once the byte three places later (or the page's
//   last byte) has been transferred and passed through the input register and the queue.
// Throughput: one byte per cycle while req_stall is low; a page end releases up to four
//   results at once into a 16-entry queue; req_stall is high while over 8 are queued.
// Reset (synchronous): page_size 1, sequence counter 2, window, position, record state
//   and queue cleared.
`default_nettype none

module record_sequence_renumberer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_page_done,
   output logic [15:0]                        rsp_next_sequence,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rsr_pkg::PageBits-1:0]  csr_page_size
);

   logic                              in_v_ff, in_v_in;
   logic [7:0]                        in_byte_ff, in_byte_in;
   logic [rsr_pkg::PageBits-1:0]      page_size_ff, page_size_in;
   rsr_pkg::push_type                 push;
   rsr_pkg::result_type               head;
   logic [rsr_pkg::CountBits-1:0]     count;
   logic                              pop;

   assign req_stall = count > rsr_pkg::CountBits'(rsr_pkg::StallLevel);
   assign csr_ready = 1'b1;
   assign rsp_valid = count != '0;
   assign pop       = rsp_valid && !rsp_stall;

   assign in_v_in      = req_valid && !req_stall;
   assign in_byte_in   = req_data_byte;
   assign page_size_in = (csr_valid && csr_ready) ? csr_page_size : page_size_ff;

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (reset) begin
         in_v_ff      <= 1'b0;
         page_size_ff <= rsr_pkg::PageSizeReset;
      end else begin
         in_v_ff      <= in_v_in;
         page_size_ff <= page_size_in;
      end
   end

   rsr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .in_byte   (in_byte_ff),
      .page_size (page_size_ff),
      .push      (push)
   );

   rsr_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (count)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_page_done     = head.page_done;
   assign rsp_next_sequence = head.next_sequence;

endmodule

`default_nettype wire
